// File: sv/software_timer_table_macros.svh
// Assertion macros for the software timer table
`ifndef SOFTWARE_TIMER_TABLE_MACROS_SVH
`define SOFTWARE_TIMER_TABLE_MACROS_SVH

// Same-cycle implication, checked outside reset
`define STT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define STT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/stt_pkg.sv
// Package: sizes, command codes and structs of the software timer table
`timescale 1ns / 1ps
`default_nettype none

package stt_pkg;

  localparam int TIMERS    = 16;
  localparam int TICK_BITS = 32;
  localparam int ID_W      = $clog2(TIMERS);

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_MODIFY = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [3:0]  timer_id;
    logic [31:0] expiry;
    logic [31:0] payload;
    logic [31:0] now;
  } stt_in_t;

  typedef struct packed {
    logic [3:0]  fired_id;
    logic [31:0] fired_payload;
    logic        last;
  } stt_out_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic            exec;
    logic            tick_load;
    logic            step;
    logic [ID_W-1:0] rank_ptr;
  } stt_ctl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic              match_any;
    logic              hit;
    logic [TIMERS-1:0] hit_vec;
  } stt_status_t;

endpackage

`default_nettype wire

// File: sv/stt_ctrl.sv
// Controller: accepts commands and walks the recency order during a tick
`timescale 1ns / 1ps
`default_nettype none

module stt_ctrl
  import stt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire cmd_t        cmd,
  input  wire stt_status_t st,
  output logic             busy,
  output stt_ctl_t         ctl
);

  typedef enum logic {
    S_IDLE,
    S_EMIT
  } state_t;

  state_t          state_r, state_nxt;
  logic [ID_W-1:0] ptr_r, ptr_nxt;

  // Decode commands for the datapath
  always_comb begin
    ctl.exec      = (state_r == S_IDLE) && start && (cmd != CMD_TICK);
    ctl.tick_load = (state_r == S_IDLE) && start && (cmd == CMD_TICK);
    ctl.step      = (state_r == S_EMIT) && st.match_any;
    ctl.rank_ptr  = ptr_r;
  end

  assign busy = (state_r == S_EMIT);

  // Advance the rank pointer past non-matching ranks; hold it after a fire
  always_comb begin
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    case (state_r)
      S_IDLE: begin
        if (ctl.tick_load) begin
          state_nxt = S_EMIT;
          ptr_nxt   = '0;
        end
      end
      S_EMIT: begin
        if (!st.match_any) begin
          state_nxt = S_IDLE;
        end else if (!st.hit) begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ptr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/stt_datapath.sv
// Datapath: slot table, recency ranks, match vector and result register
`timescale 1ns / 1ps
`default_nettype none

module stt_datapath
  import stt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire stt_in_t  in_item,
  input  wire stt_ctl_t ctl,
  output stt_status_t   st,
  output logic          out_valid,
  output stt_out_t      out_item
);

  logic [TIMERS-1:0]    active_r, active_nxt;
  logic [TIMERS-1:0]    match_r, match_nxt;
  logic [ID_W-1:0]      rank_r [TIMERS];
  logic [ID_W-1:0]      rank_nxt [TIMERS];
  logic [TICK_BITS-1:0] expiry_r [TIMERS];
  logic [31:0]          payload_r [TIMERS];

  logic                 out_valid_r;
  stt_out_t             out_item_r;

  logic [ID_W-1:0]      id;
  logic                 link;
  logic                 tgt_active;
  logic [ID_W-1:0]      tgt_rank;
  logic [TIMERS-1:0]    hit_vec;
  logic [ID_W-1:0]      sel;

  assign id         = in_item.timer_id[ID_W-1:0];
  assign link       = (in_item.cmd == CMD_ADD) || (in_item.cmd == CMD_MODIFY);
  assign tgt_active = active_r[id];
  assign tgt_rank   = rank_r[id];

  // Find the matched slot at the current rank and encode its index
  always_comb begin
    sel = '0;
    for (int i = 0; i < TIMERS; i++) begin
      hit_vec[i] = active_r[i] && match_r[i] && (rank_r[i] == ctl.rank_ptr);
      if (hit_vec[i]) begin
        sel = sel | ID_W'(i);
      end
    end
  end

  always_comb begin
    st.match_any = |match_r;
    st.hit       = |hit_vec;
    st.hit_vec   = hit_vec;
  end

  // Next active marks, ranks and match vector
  always_comb begin
    active_nxt = active_r;
    match_nxt  = match_r;
    for (int i = 0; i < TIMERS; i++) begin
      rank_nxt[i] = rank_r[i];
    end
    if (ctl.exec) begin
      // Unlink the addressed slot, then put it at the front on add or modify
      for (int i = 0; i < TIMERS; i++) begin
        if (ID_W'(i) == id) begin
          active_nxt[i] = link;
          rank_nxt[i]   = '0;
        end else if (active_r[i]) begin
          rank_nxt[i] = rank_r[i]
                        - ID_W'(tgt_active && (rank_r[i] > tgt_rank))
                        + ID_W'(link);
        end
      end
    end else if (ctl.tick_load) begin
      for (int i = 0; i < TIMERS; i++) begin
        match_nxt[i] = active_r[i]
                       && (expiry_r[i] == in_item.now[TICK_BITS-1:0]);
      end
    end else if (ctl.step && st.hit) begin
      // Free the fired slot and close the gap behind it
      active_nxt = active_r & ~hit_vec;
      match_nxt  = match_r & ~hit_vec;
      for (int i = 0; i < TIMERS; i++) begin
        if (active_r[i] && (rank_r[i] > ctl.rank_ptr)) begin
          rank_nxt[i] = rank_r[i] - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= '0;
      match_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < TIMERS; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      active_r    <= active_nxt;
      match_r     <= match_nxt;
      out_valid_r <= ctl.step && st.hit;
      for (int i = 0; i < TIMERS; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
  end

  // Write expiry and payload words
  always_ff @(posedge clk) begin
    if (ctl.exec && link) begin
      expiry_r[id] <= in_item.expiry[TICK_BITS-1:0];
    end
    if (ctl.exec && (in_item.cmd == CMD_ADD)) begin
      payload_r[id] <= in_item.payload;
    end
  end

  // Capture the fire result; last when no other match remains
  always_ff @(posedge clk) begin
    if (ctl.step && st.hit) begin
      out_item_r.fired_id      <= 4'(sel);
      out_item_r.fired_payload <= payload_r[sel];
      out_item_r.last          <= ((match_r & ~hit_vec) == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// File: sv/software_timer_table.sv
// Top level of the software timer table: controller plus datapath
//
//   channel  | ports                 | transfer
//   ---------+-----------------------+------------------------------------
//   input    | start, busy, in_item  | start high while busy is low
//   result   | out_valid, out_item   | out_valid high, one cycle per result
//
// Add, delete and modify complete at the accepting edge; busy stays low.
// A tick loads the match vector at the accepting edge, then walks the ranks
// one step a cycle: each step skips a rank with no match or fires the match
// at the current rank, and busy falls once no match is left.
// Synchronous active-low reset clears all slots to inactive.
// The receiver cannot stall; each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

`include "software_timer_table_macros.svh"

module software_timer_table
  import stt_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  input  wire stt_in_t in_item,
  output logic         out_valid,
  output stt_out_t     out_item
);

  stt_ctl_t    ctl;
  stt_status_t st;

  stt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .cmd   (in_item.cmd),
    .st    (st),
    .busy  (busy),
    .ctl   (ctl)
  );

  stt_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .ctl       (ctl),
    .st        (st),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  `STT_ASSERT_NEXT(a_cmd_no_busy, start && !busy && (in_item.cmd != CMD_TICK), !busy, "timer command left the block busy")
  `STT_ASSERT_NOW(a_more_pending, out_valid && !out_item.last, busy, "non-final fire without a scan in progress")
  `STT_ASSERT_NOW(a_rank_unique, 1'b1, $onehot0(st.hit_vec), "two matched slots share one rank")
  `STT_ASSERT_NEXT(a_fire_in_scan, ctl.step && st.hit, out_valid, "fire step did not produce a result")

endmodule

`default_nettype wire

// File: bench/stt_fire_checker.sv
// Checker for the software timer table: predicts fire results and compares them
`timescale 1ns / 1ps

module stt_fire_checker
  import stt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire logic     busy,
  input  wire stt_in_t  in_item,
  input  wire logic     out_valid,
  input  wire stt_out_t out_item,
  output int            mismatches,
  output int            fires_pending
);

  localparam int MAX_REPORTS = 10;

  // Shadow copy of the slot table
  logic            slot_on   [TIMERS];
  logic [31:0]     slot_exp  [TIMERS];
  logic [31:0]     slot_pay  [TIMERS];
  logic [ID_W-1:0] slot_rank [TIMERS];

  stt_out_t fire_q[$];
  int       n_bad = 0;

  // Take an active slot out of the recency order and free it
  function automatic void unlink_slot(int s);
    if (!slot_on[s]) return;
    for (int i = 0; i < TIMERS; i++)
      if (slot_on[i] && slot_rank[i] > slot_rank[s]) slot_rank[i]--;
    slot_on[s]   = 1'b0;
    slot_rank[s] = '0;
  endfunction

  // Put an inactive slot at the front of the recency order
  function automatic void link_front(int s);
    for (int i = 0; i < TIMERS; i++)
      if (slot_on[i]) slot_rank[i]++;
    slot_on[s]   = 1'b1;
    slot_rank[s] = '0;
  endfunction

  // Queue one fire per exact match, front to back, and free the fired slots
  function automatic void predict_tick(logic [31:0] now);
    int       hits[$];
    stt_out_t f;
    for (int r = 0; r < TIMERS; r++)
      for (int i = 0; i < TIMERS; i++)
        if (slot_on[i] && slot_rank[i] == r) begin
          if (slot_exp[i] == now) hits.push_back(i);
          break;
        end
    for (int k = 0; k < hits.size(); k++) begin
      f.fired_id      = 4'(hits[k]);
      f.fired_payload = slot_pay[hits[k]];
      f.last          = (k == hits.size() - 1);
      fire_q.push_back(f);
      unlink_slot(hits[k]);
    end
  endfunction

  function automatic void apply_item(stt_in_t it);
    case (it.cmd)
      CMD_ADD: begin
        unlink_slot(it.timer_id);
        slot_exp[it.timer_id] = it.expiry;
        slot_pay[it.timer_id] = it.payload;
        link_front(it.timer_id);
      end
      CMD_DELETE: begin
        unlink_slot(it.timer_id);
      end
      CMD_MODIFY: begin
        unlink_slot(it.timer_id);
        slot_exp[it.timer_id] = it.expiry;
        link_front(it.timer_id);
      end
      CMD_TICK: begin
        predict_tick(it.now);
      end
      default: begin
      end
    endcase
  endfunction

  always @(posedge clk) begin
    stt_out_t want;
    if (!rst_n) begin
      for (int i = 0; i < TIMERS; i++) begin
        slot_on[i]   = 1'b0;
        slot_exp[i]  = '0;
        slot_pay[i]  = '0;
        slot_rank[i] = '0;
      end
      fire_q.delete();
    end else begin
      // Match a result transfer against the oldest expected fire
      if (out_valid) begin
        if (fire_q.size() == 0) begin
          n_bad++;
          if (n_bad <= MAX_REPORTS)
            $display("unexpected fire: id %0d payload %h last %0b",
                     out_item.fired_id, out_item.fired_payload, out_item.last);
        end else begin
          want = fire_q.pop_front();
          if (out_item.fired_id !== want.fired_id ||
              out_item.fired_payload !== want.fired_payload ||
              out_item.last !== want.last) begin
            n_bad++;
            if (n_bad <= MAX_REPORTS)
              $display("fire mismatch: expected id %0d payload %h last %0b, got id %0d payload %h last %0b",
                       want.fired_id, want.fired_payload, want.last,
                       out_item.fired_id, out_item.fired_payload, out_item.last);
          end
        end
      end
      // Advance the shadow table on an input transfer
      if (start && !busy) apply_item(in_item);
    end
    mismatches    <= n_bad;
    fires_pending <= fire_q.size();
  end

endmodule

// File: bench/testbench.sv
// Testbench top for the software timer table: stimulus, watchdog and verdict
`timescale 1ns / 1ps

module testbench;
  import stt_pkg::*;

  localparam int ITEMS        = 200;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;

  logic     clk;
  logic     rst_n   = 1'b0;
  logic     start   = 1'b0;
  stt_in_t  in_item = '0;
  logic     busy;
  logic     out_valid;
  stt_out_t out_item;
  int       mismatches;
  int       fires_pending;

  int              n_sent  = 0;
  int              quiet   = 0;
  bit              gaps_on = 1'b1;
  logic [TIMERS-1:0] ever_added = '0;

  software_timer_table u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  stt_fire_checker u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_item      (in_item),
    .out_valid    (out_valid),
    .out_item     (out_item),
    .mismatches   (mismatches),
    .fires_pending(fires_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic stt_in_t noise_item();
    stt_in_t it;
    it.cmd      = cmd_t'($urandom_range(0, 3));
    it.timer_id = 4'($urandom);
    it.expiry   = $urandom;
    it.payload  = $urandom;
    it.now      = $urandom;
    return it;
  endfunction

  // Present one item and hold it until the block takes it
  task automatic send(stt_in_t it);
    // never modify a slot whose payload was never written
    if (it.cmd == CMD_MODIFY && !ever_added[it.timer_id]) it.cmd = CMD_ADD;
    if (it.cmd == CMD_ADD) ever_added[it.timer_id] = 1'b1;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    n_sent++;
  endtask

  task automatic send_cmd(cmd_t c, logic [3:0] id, logic [31:0] e, logic [31:0] p);
    stt_in_t it;
    it          = noise_item();
    it.cmd      = c;
    it.timer_id = id;
    it.expiry   = e;
    it.payload  = p;
    send(it);
  endtask

  task automatic send_tick(logic [31:0] n);
    stt_in_t it;
    it     = noise_item();
    it.cmd = CMD_TICK;
    it.now = n;
    send(it);
  endtask

  // Drop start and hold off until every expected fire has been seen
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (fires_pending != 0) @(posedge clk);
  endtask

  initial begin
    logic [31:0] tick_at;
    int          pick;
    int          depth;
    int          j;
    int          tmp;
    int          order[TIMERS];
    bit          paused_mid;
    paused_mid = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Extremes of id, expiry and payload, a tick firing each, then a tick with no match
    send_cmd(CMD_ADD, 4'd0, 32'h0, 32'h0);
    send_cmd(CMD_ADD, 4'd15, '1, '1);
    send_tick(32'h0);
    send_tick('1);
    send_tick(32'h1);
    // Recency order, re-adding an active slot, modify of an active slot
    send_cmd(CMD_ADD, 4'd3, 32'd100, $urandom);
    send_cmd(CMD_ADD, 4'd5, 32'd100, $urandom);
    send_cmd(CMD_ADD, 4'd7, 32'd100, $urandom);
    send_cmd(CMD_ADD, 4'd5, 32'd100, $urandom);
    send_cmd(CMD_MODIFY, 4'd7, 32'd200, $urandom);
    // delete of a slot that is not active
    send_cmd(CMD_DELETE, 4'd9, $urandom, $urandom);
    send_tick(32'd100);
    // modify of a freed slot keeps its old payload
    send_cmd(CMD_MODIFY, 4'd3, 32'd200, $urandom);
    send_cmd(CMD_DELETE, 4'd7, $urandom, $urandom);
    send_tick(32'd200);
    // a slot whose expiry has passed stays pending
    send_cmd(CMD_ADD, 4'd8, 32'd300, $urandom);
    send_tick(32'd301);
    wait_drained();

    // Random bursts: arm timers around one tick value, then tick it
    while (n_sent < ITEMS) begin
      if (n_sent >= ITEMS - 30) gaps_on = 1'b0;
      if (!paused_mid && n_sent >= ITEMS / 2) begin
        wait_drained();
        paused_mid = 1'b1;
      end
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        send(noise_item());
      end else begin
        tick_at = ($urandom_range(0, 2) == 0) ? $urandom : 32'($urandom_range(0, 7));
        if (pick == 9) begin
          // fill the whole table in a shuffled order
          for (int i = 0; i < TIMERS; i++) order[i] = i;
          for (int i = TIMERS - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
          end
          for (int i = 0; i < TIMERS; i++)
            send_cmd(CMD_ADD, 4'(order[i]), tick_at, $urandom);
        end else begin
          depth = $urandom_range(1, 6);
          repeat (depth) begin
            case ($urandom_range(0, 5))
              0: send_cmd(CMD_MODIFY, 4'($urandom),
                          $urandom_range(0, 1) ? tick_at : tick_at + 1, $urandom);
              1: send_cmd(CMD_DELETE, 4'($urandom), $urandom, $urandom);
              default: send_cmd(CMD_ADD, 4'($urandom),
                                ($urandom_range(0, 3) == 0) ? tick_at + 1 : tick_at,
                                $urandom);
            endcase
          end
        end
        send_tick(tick_at);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && fires_pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
